@@ rtl/pcfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color format converter package
// Shared types, constants and the fixed palette for the converter.
// ----------------------------------------------------------------------------
package pcfc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = 8;
    localparam int DIST_W          = 18;
    localparam int WORD_W          = 32;

    typedef enum logic [1:0] {
        MODE_PAL8     = 2'd0,
        MODE_RGB565   = 2'd1,
        MODE_RGB888   = 2'd2,
        MODE_RGBA8888 = 2'd3
    } color_mode_t;

    typedef enum logic {
        CMD_PACK   = 1'b0,
        CMD_UNPACK = 1'b1
    } conv_cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } ctrl_state_t;

    localparam color_mode_t MODE_RESET = MODE_RGBA8888;

    typedef struct packed {
        logic load_direct;
        logic start_search;
        logic step_search;
        logic finish_search;
    } dp_cmd_t;

    typedef struct packed {
        logic search_needed;
        logic search_last;
    } dp_status_t;

    // Fixed VGA palette; entries from 64 upward are black.
    function automatic logic [23:0] palette_entry(input logic [IDX_W-1:0] idx);
        logic [23:0] e;
        e = 24'h000000;
        if (idx < IDX_W'(64)) begin
            case (idx[5:0])
                6'd0:  e = 24'h000000;  6'd1:  e = 24'h0000A8;
                6'd2:  e = 24'h00A800;  6'd3:  e = 24'h00A8A8;
                6'd4:  e = 24'hA80000;  6'd5:  e = 24'hA800A8;
                6'd6:  e = 24'hA8A800;  6'd7:  e = 24'hA8A8A8;
                6'd8:  e = 24'h000057;  6'd9:  e = 24'h0000FF;
                6'd10: e = 24'h00A857;  6'd11: e = 24'h00A8FF;
                6'd12: e = 24'hA80057;  6'd13: e = 24'hA80057;
                6'd14: e = 24'hA8A857;  6'd15: e = 24'hA8A8FF;
                6'd16: e = 24'h005700;  6'd17: e = 24'h0057A8;
                6'd18: e = 24'h00FF00;  6'd19: e = 24'h00FFA8;
                6'd20: e = 24'hA85700;  6'd21: e = 24'hA857A8;
                6'd22: e = 24'hA8FF00;  6'd23: e = 24'hA8FFA8;
                6'd24: e = 24'h005757;  6'd25: e = 24'h0057FF;
                6'd26: e = 24'h00FF57;  6'd27: e = 24'h00FFFF;
                6'd28: e = 24'hA85757;  6'd29: e = 24'hA857FF;
                6'd30: e = 24'hA8FF57;  6'd31: e = 24'hA8FFFF;
                6'd32: e = 24'h570000;  6'd33: e = 24'h5700A8;
                6'd34: e = 24'h57A800;  6'd35: e = 24'h57A8A8;
                6'd36: e = 24'hFF0000;  6'd37: e = 24'hFF00A8;
                6'd38: e = 24'hFFA800;  6'd39: e = 24'hFFA8A8;
                6'd40: e = 24'h570057;  6'd41: e = 24'h5700FF;
                6'd42: e = 24'h57A857;  6'd43: e = 24'h57A8FF;
                6'd44: e = 24'hFF0057;  6'd45: e = 24'hFF00FF;
                6'd46: e = 24'hFFA857;  6'd47: e = 24'hFFA8FF;
                6'd48: e = 24'h575700;  6'd49: e = 24'h5757A8;
                6'd50: e = 24'h57FF00;  6'd51: e = 24'h57FFA8;
                6'd52: e = 24'hFF5700;  6'd53: e = 24'hFF57A8;
                6'd54: e = 24'hFFFF00;  6'd55: e = 24'hFFFFA8;
                6'd56: e = 24'h575757;  6'd57: e = 24'h5757FF;
                6'd58: e = 24'h57FF57;  6'd59: e = 24'h57FFFF;
                6'd60: e = 24'hFF5757;  6'd61: e = 24'hFF57FF;
                6'd62: e = 24'hFFFF57;  6'd63: e = 24'hFFFFFF;
                default: e = 24'h000000;
            endcase
        end
        return e;
    endfunction

endpackage

@@ rtl/pcfc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color format converter controller
// Sequences the input handshake, the palette search and the output register.
// ----------------------------------------------------------------------------
module pcfc_ctrl
    import pcfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new word may enter while the held result is taken in the same cycle.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.search_needed)
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.load_direct = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step_search = 1'b1;
                if (status.search_last)
                begin
                    cmd.finish_search = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_direct || cmd.finish_search)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    a_no_accept_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> !in_ready)
        else $error("input accepted during palette search");

    a_slot_free_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_search |-> !out_valid_reg)
        else $error("search finished while a result was still held");

    a_search_entered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_search |=> state_reg == ST_SEARCH && !out_valid_reg)
        else $error("palette search did not start");

    a_search_continues: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH && !status.search_last |=> state_reg == ST_SEARCH)
        else $error("palette search ended early");

endmodule

@@ rtl/pcfc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color format converter datapath
// Holds the mode register, the direct pack and unpack logic, the palette
// distance unit with its running best, and the result register.
// ----------------------------------------------------------------------------
module pcfc_datapath
    import pcfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              cmd_in,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic [7:0]        alpha_in,
    input  logic [WORD_W-1:0] packed_in,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output logic [WORD_W-1:0] packed_out,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic [7:0]        alpha_out
);

    color_mode_t       mode_reg;
    logic [7:0]        r_reg, g_reg, b_reg;
    logic [IDX_W-1:0]  idx_reg, best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [WORD_W-1:0] packed_reg, packed_next;
    logic [7:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]        red_next, green_next, blue_next, alpha_next;

    logic [23:0]       entry;
    logic [DIST_W-1:0] entry_dist;
    logic              better;
    logic [IDX_W-1:0]  win_idx;
    logic [23:0]       lut_entry;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= color_mode_t'(cfg_wdata);
        end
    end

    assign status.search_needed = (conv_cmd_t'(cmd_in) == CMD_PACK) && (mode_reg == MODE_PAL8);
    assign status.search_last   = (idx_reg == IDX_W'(PALETTE_ENTRIES - 1));

    // One palette entry is scored per cycle; ties keep the earlier index.
    assign entry      = palette_entry(idx_reg);
    assign entry_dist = DIST_W'(sq_diff(r_reg, entry[23:16]))
                      + DIST_W'(sq_diff(g_reg, entry[15:8]))
                      + DIST_W'(sq_diff(b_reg, entry[7:0]));
    assign better     = (entry_dist < best_dist_reg);
    assign win_idx    = better ? idx_reg : best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            r_reg         <= red_in;
            g_reg         <= green_in;
            b_reg         <= blue_in;
            idx_reg       <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '1;
        end
        else if (cmd.step_search)
        begin
            idx_reg       <= idx_reg + IDX_W'(1);
            best_idx_reg  <= win_idx;
            if (better)
            begin
                best_dist_reg <= entry_dist;
            end
        end
    end

    // Unpack lookup: indices beyond the palette read as black.
    always_comb
    begin
        if ({1'b0, packed_in[IDX_W-1:0]} < (IDX_W + 1)'(PALETTE_ENTRIES))
        begin
            lut_entry = palette_entry(packed_in[IDX_W-1:0]);
        end
        else
        begin
            lut_entry = 24'h000000;
        end
    end

    always_comb
    begin
        packed_next = '0;
        red_next    = '0;
        green_next  = '0;
        blue_next   = '0;
        alpha_next  = '0;
        if (cmd.finish_search)
        begin
            packed_next = WORD_W'(win_idx);
        end
        else if (conv_cmd_t'(cmd_in) == CMD_PACK)
        begin
            case (mode_reg)
                MODE_RGB565:
                    packed_next = {16'h0000, red_in[7:3], green_in[7:2], blue_in[7:3]};
                MODE_RGB888:
                    packed_next = {8'h00, red_in, green_in, blue_in};
                MODE_RGBA8888:
                    packed_next = {red_in, green_in, blue_in, alpha_in};
                default:
                    packed_next = '0;
            endcase
        end
        else
        begin
            alpha_next = 8'hFF;
            case (mode_reg)
                MODE_PAL8:
                begin
                    red_next   = lut_entry[23:16];
                    green_next = lut_entry[15:8];
                    blue_next  = lut_entry[7:0];
                end
                MODE_RGB565:
                begin
                    red_next   = {packed_in[15:11], 3'b000};
                    green_next = {packed_in[10:5], 2'b00};
                    blue_next  = {packed_in[4:0], 3'b000};
                end
                MODE_RGB888:
                begin
                    red_next   = packed_in[23:16];
                    green_next = packed_in[15:8];
                    blue_next  = packed_in[7:0];
                end
                default:
                begin
                    red_next   = packed_in[31:24];
                    green_next = packed_in[23:16];
                    blue_next  = packed_in[15:8];
                    alpha_next = packed_in[7:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_direct || cmd.finish_search)
        begin
            packed_reg <= packed_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            alpha_reg  <= alpha_next;
        end
    end

    assign packed_out = packed_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign alpha_out  = alpha_reg;

    a_search_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_search && !status.search_last |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("palette index did not advance");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_search |=> best_dist_reg <= $past(best_dist_reg))
        else $error("best distance grew during search");

    a_best_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_search |-> best_idx_reg <= idx_reg)
        else $error("best index ahead of search index");

endmodule

@@ rtl/pixel_color_format_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color format converter
// Converts between RGBA components and 8/16/24/32-bit framebuffer words.
// ----------------------------------------------------------------------------
// Timing: pack, unpack and palette lookup give the result in the cycle after
// the input word is accepted; a nearest-palette pack in 8-bit mode gives it
// once 256 entries are scored one per cycle by a single unit. Direct words
// go at one per cycle while out_ready is high; none enters during a search.
// Reset clears the handshake state and sets 32-bit mode.
// ----------------------------------------------------------------------------
module pixel_color_format_converter
    import pcfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic [7:0]        alpha_in,
    input  logic [WORD_W-1:0] packed_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] packed_out,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic [7:0]        alpha_out
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    pcfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    pcfc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_in     (cmd),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .packed_in  (packed_in),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .packed_out (packed_out),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out)
    );

endmodule
